// ===== src/ssbf_pkg.sv =====
// Shared types, constants and helpers of the SD card SPI stream bank filler.
`timescale 1ns / 1ps
`default_nettype none

package ssbf_pkg;

  localparam int unsigned ADDR_W       = 10;
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned FRAME_BYTES  = 8;
  localparam int unsigned Q_DEPTH      = 2;

  localparam logic [7:0]  TOKEN        = 8'hFE;
  localparam logic [7:0]  FILL_BYTE    = 8'hFF;
  localparam logic [7:0]  CRC_BYTE     = 8'h95;
  localparam logic [7:0]  CMD_MARK     = 8'h40;
  localparam logic [7:0]  CMD_READ_MB  = 8'd18;
  localparam logic [7:0]  CMD_STOP     = 8'd12;
  localparam logic [15:0] TIMEOUT_RST  = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_RX    = 2'd2
  } mode_e;

  // What the back part has to emit for one accepted item.
  typedef enum logic [2:0] {
    OP_SINGLE  = 3'd0,
    OP_START   = 3'd1,
    OP_RESTART = 3'd2,
    OP_STOP    = 3'd3,
    OP_TIMEOUT = 3'd4
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [31:0]       arg;
    logic              cs;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              done;
    logic [31:0]       sector;
    logic              active;
  } desc_t;

  typedef struct packed {
    logic [7:0]        tx;
    logic              cs;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              done;
    logic              err;
    logic [31:0]       sector;
    logic              active;
    logic              last;
  } res_t;

  // Byte i of a command frame: filler, command, four argument bytes, CRC, filler.
  function automatic logic [7:0] frame_byte(input logic [7:0] cmd, input logic [31:0] arg,
                                            input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = FILL_BYTE;
      3'd1:    b = cmd | CMD_MARK;
      3'd2:    b = arg[31:24];
      3'd3:    b = arg[23:16];
      3'd4:    b = arg[15:8];
      3'd5:    b = arg[7:0];
      3'd6:    b = CRC_BYTE;
      default: b = FILL_BYTE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== src/ssbf_front.sv =====
// Front part: accepts items, keeps the stream state and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module ssbf_front #(
  parameter int unsigned BANK_SIZE = 262
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                fire_i,
  input  wire logic [1:0]          mode_i,
  input  wire logic [31:0]         lba_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                bank_select_i,
  output logic                     push_o,
  output ssbf_pkg::desc_t          desc_o
);

  localparam int unsigned BFC_W = $clog2(BANK_SIZE + 1);
  localparam int unsigned SBC_W = $clog2(ssbf_pkg::SECTOR_BYTES);

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_DATA = 3'b010,
    PH_CRC  = 3'b100
  } phase_e;

  logic [15:0]      timeout_q;
  logic             active_q, active_d;
  logic [31:0]      sector_q, sector_d;
  phase_e           phase_q, phase_d;
  logic [SBC_W-1:0] sbc_q, sbc_d;
  logic             crc_q, crc_d;
  logic [BFC_W-1:0] bfc_q, bfc_d;
  logic             bank_q, bank_d;
  logic [15:0]      wait_q, wait_d;
  logic [15:0]      wait_next;
  logic             fb;

  assign wait_next = wait_q + 16'd1;
  assign fb        = (bfc_q == '0) ? bank_select_i : bank_q;

  always_comb begin
    active_d = active_q;
    sector_d = sector_q;
    phase_d  = phase_q;
    sbc_d    = sbc_q;
    crc_d    = crc_q;
    bfc_d    = bfc_q;
    bank_d   = bank_q;
    wait_d   = wait_q;
    push_o   = 1'b0;
    desc_o   = '0;
    desc_o.op = ssbf_pkg::OP_SINGLE;
    if (fire_i) begin
      unique case (mode_i)
        ssbf_pkg::MODE_START: begin
          push_o     = 1'b1;
          desc_o.op  = active_q ? ssbf_pkg::OP_RESTART : ssbf_pkg::OP_START;
          desc_o.arg = {lba_i[22:0], 9'd0};
          sector_d   = lba_i;
          active_d   = 1'b1;
          phase_d    = PH_WAIT;
          sbc_d      = '0;
          crc_d      = 1'b0;
          bfc_d      = '0;
          wait_d     = '0;
        end
        ssbf_pkg::MODE_STOP: begin
          push_o    = active_q;
          desc_o.op = ssbf_pkg::OP_STOP;
          active_d  = 1'b0;
          phase_d   = PH_WAIT;
          sbc_d     = '0;
          crc_d     = 1'b0;
          bfc_d     = '0;
          wait_d    = '0;
        end
        ssbf_pkg::MODE_RX: begin
          push_o = 1'b1;
          if (active_q) begin
            desc_o.cs = 1'b1;
            unique case (phase_q)
              PH_DATA: begin
                bank_d      = fb;
                desc_o.wr   = 1'b1;
                desc_o.data = rx_byte_i;
                desc_o.addr = (fb ? ssbf_pkg::ADDR_W'(BANK_SIZE) : '0)
                              + ssbf_pkg::ADDR_W'(bfc_q);
                if (bfc_q == BFC_W'(BANK_SIZE - 1)) begin
                  bfc_d       = '0;
                  desc_o.done = 1'b1;
                end else begin
                  bfc_d = bfc_q + BFC_W'(1);
                end
                if (sbc_q == SBC_W'(ssbf_pkg::SECTOR_BYTES - 1)) begin
                  sbc_d   = '0;
                  crc_d   = 1'b0;
                  phase_d = PH_CRC;
                end else begin
                  sbc_d = sbc_q + SBC_W'(1);
                end
              end
              PH_CRC: begin
                if (crc_q) begin
                  crc_d    = 1'b0;
                  sector_d = sector_q + 32'd1;
                  phase_d  = PH_WAIT;
                  wait_d   = '0;
                end else begin
                  crc_d = 1'b1;
                end
              end
              default: begin
                if (rx_byte_i == ssbf_pkg::TOKEN) begin
                  phase_d = PH_DATA;
                  wait_d  = '0;
                  sbc_d   = '0;
                end else if (wait_next >= timeout_q || wait_next == '0) begin
                  // The card never answered: release it and drop the stream.
                  desc_o.op = ssbf_pkg::OP_TIMEOUT;
                  active_d  = 1'b0;
                  phase_d   = PH_WAIT;
                  sbc_d     = '0;
                  crc_d     = 1'b0;
                  bfc_d     = '0;
                  wait_d    = '0;
                end else begin
                  wait_d = wait_next;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    desc_o.sector = sector_d;
    desc_o.active = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ssbf_pkg::TIMEOUT_RST;
      active_q  <= 1'b0;
      sector_q  <= '0;
      phase_q   <= PH_WAIT;
      sbc_q     <= '0;
      crc_q     <= 1'b0;
      bfc_q     <= '0;
      bank_q    <= 1'b0;
      wait_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      active_q <= active_d;
      sector_q <= sector_d;
      phase_q  <= phase_d;
      sbc_q    <= sbc_d;
      crc_q    <= crc_d;
      bfc_q    <= bfc_d;
      bank_q   <= bank_d;
      wait_q   <= wait_d;
    end
  end

  a_idle_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (phase_q == PH_WAIT && bfc_q == '0 && wait_q == '0))
    else $error("idle stream left stream state behind");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bfc_q < BFC_W'(BANK_SIZE))
    else $error("bank fill position out of range");

endmodule

`default_nettype wire

// ===== src/ssbf_queue.sv =====
// Short queue of classified items between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none

module ssbf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ssbf_pkg::desc_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output ssbf_pkg::desc_t      head_o
);

  localparam int unsigned PTR_W = $clog2(ssbf_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(ssbf_pkg::Q_DEPTH + 1);

  ssbf_pkg::desc_t  mem_q [ssbf_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(ssbf_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

endmodule

`default_nettype wire

// ===== src/ssbf_back.sv =====
// Back part: expands each queued item into its SPI byte transfers.
`timescale 1ns / 1ps
`default_nettype none

module ssbf_back #(
  parameter int unsigned RELEASE_BYTES = 10
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire ssbf_pkg::desc_t head_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output ssbf_pkg::res_t       m_res_o
);

  localparam int unsigned IDX_W = $clog2(2 * ssbf_pkg::FRAME_BYTES + RELEASE_BYTES + 1);
  localparam logic [IDX_W-1:0] FRM = IDX_W'(ssbf_pkg::FRAME_BYTES);
  localparam logic [IDX_W-1:0] REL = IDX_W'(RELEASE_BYTES);

  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] total;
  logic [IDX_W-1:0] rel_idx;
  logic [IDX_W-1:0] frm_idx;
  logic             is_last;
  logic             advance;
  logic             valid_q;
  ssbf_pkg::res_t   res_q, res;

  assign advance   = !empty_i && (!valid_q || m_ready_i);
  assign is_last   = (idx_q == total - IDX_W'(1));
  assign pop_o     = advance && is_last;
  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

  always_comb begin
    total   = IDX_W'(1);
    rel_idx = idx_q;
    frm_idx = idx_q;
    res        = '0;
    res.tx     = ssbf_pkg::FILL_BYTE;
    res.cs     = 1'b1;
    res.sector = head_i.sector;
    res.active = head_i.active;
    res.last   = is_last;
    unique case (head_i.op)
      ssbf_pkg::OP_SINGLE: begin
        total    = IDX_W'(1);
        res.cs   = head_i.cs;
        res.wr   = head_i.wr;
        res.addr = head_i.addr;
        res.data = head_i.data;
        res.done = head_i.done;
      end
      ssbf_pkg::OP_START: begin
        total  = FRM;
        res.tx = ssbf_pkg::frame_byte(ssbf_pkg::CMD_READ_MB, head_i.arg, idx_q[2:0]);
      end
      ssbf_pkg::OP_STOP: begin
        total   = FRM + REL;
        rel_idx = idx_q - FRM;
        if (idx_q < FRM) begin
          res.tx = ssbf_pkg::frame_byte(ssbf_pkg::CMD_STOP, 32'd0, idx_q[2:0]);
        end else begin
          res.cs = (rel_idx != REL - IDX_W'(1));
        end
      end
      ssbf_pkg::OP_RESTART: begin
        total   = FRM + REL + FRM;
        rel_idx = idx_q - FRM;
        frm_idx = idx_q - FRM - REL;
        if (idx_q < FRM) begin
          res.tx = ssbf_pkg::frame_byte(ssbf_pkg::CMD_STOP, 32'd0, idx_q[2:0]);
        end else if (idx_q < FRM + REL) begin
          res.cs = (rel_idx != REL - IDX_W'(1));
        end else begin
          res.tx = ssbf_pkg::frame_byte(ssbf_pkg::CMD_READ_MB, head_i.arg, frm_idx[2:0]);
        end
      end
      ssbf_pkg::OP_TIMEOUT: begin
        total  = REL;
        res.err = 1'b1;
        res.cs  = (idx_q != REL - IDX_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (advance) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + IDX_W'(1);
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < total)
    else $error("sequence position beyond the end of the item");

  a_idx_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0)
    else $error("sequence position not rewound after the last transfer");

endmodule

`default_nettype wire

// ===== src/sd_spi_stream_bank_filler.sv =====
// Top level of the SD card SPI multi-block read stream bank filler.
// A result passes through the queue and the back part's output register to the master side.
// Throughput: one transfer per cycle on either side unless stalled; an item with N results
// holds the back-part sequencer for N transfers (a frame 8, a stop 8 plus the release
// bytes, a restart 16 plus them); the slave side stalls only while the queue holds two.
// Reset is asynchronous, active low; it clears all stream state and sets timeout 65535.
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_stream_bank_filler #(
  parameter int unsigned BANK_SIZE     = 262,
  parameter int unsigned RELEASE_BYTES = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Token timeout register write.
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Slave side: one request or one received card byte per transfer.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: lba[31:0], rx_byte[39:32], bank_select[40], zero pad [47:41].
  input  wire logic [47:0] s_axis_tdata,
  // tuser from bit 0: mode[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  // Master side: one SPI byte with its buffer write per transfer.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: tx_byte[7:0], chip_select[8], buf_write[9], buf_addr[19:10],
  // buf_data[27:20], bank_done[28], token_error[29], current_sector[61:30],
  // stream_active[62], zero pad [63].
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  logic            s_fire;
  logic            push;
  ssbf_pkg::desc_t push_desc;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  ssbf_pkg::desc_t head;
  ssbf_pkg::res_t  res;

  // The front part updates all stream state at the accepting edge, so it only
  // needs room in the queue to take the next item.
  assign s_axis_tready = !q_full;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  ssbf_front #(
    .BANK_SIZE (BANK_SIZE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fire_i        (s_fire),
    .mode_i        (s_axis_tuser),
    .lba_i         (s_axis_tdata[31:0]),
    .rx_byte_i     (s_axis_tdata[39:32]),
    .bank_select_i (s_axis_tdata[40]),
    .push_o        (push),
    .desc_o        (push_desc)
  );

  ssbf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // The back part walks each queued item one byte per cycle, while its output is taken,
  // into its output register, which frees the queue entry at the item's final transfer.
  ssbf_back #(
    .RELEASE_BYTES (RELEASE_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  assign m_axis_tdata = {1'b0, res.active, res.sector, res.err, res.done, res.data,
                         res.addr, res.wr, res.cs, res.tx};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== verif/ssbf_checker.sv =====
// Predicts and checks the output stream of the SD card SPI stream bank filler.
`timescale 1ns / 1ps

module ssbf_checker #(
  parameter int unsigned BANK_SIZE     = 262,
  parameter int unsigned RELEASE_BYTES = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef enum logic [1:0] {
    PH_TOKEN = 2'd0,
    PH_DATA  = 2'd1,
    PH_CRC   = 2'd2
  } rx_phase_e;

  // Shadow copy of the stream state and the timeout register.
  logic        streaming;
  logic [31:0] sector_num;
  rx_phase_e   rx_phase;
  logic [9:0]  sector_pos;
  logic [1:0]  crc_seen;
  logic [9:0]  bank_pos;
  logic        bank_id;
  logic [15:0] token_wait;
  logic [15:0] wait_limit;

  ssbf_pkg::res_t spi_bytes_q[$];
  ssbf_pkg::res_t item_bytes[$];
  int unsigned    fails = 0;

  task automatic clear_stream();
    rx_phase   = PH_TOKEN;
    sector_pos = '0;
    crc_seen   = '0;
    bank_pos   = '0;
    token_wait = '0;
  endtask

  task automatic add_byte(input logic [7:0] tx, input logic cs, input logic wr,
                          input logic [9:0] addr, input logic [7:0] data,
                          input logic done, input logic err);
    ssbf_pkg::res_t r;
    r      = '0;
    r.tx   = tx;
    r.cs   = cs;
    r.wr   = wr;
    r.addr = addr;
    r.data = data;
    r.done = done;
    r.err  = err;
    item_bytes.push_back(r);
  endtask

  task automatic add_cmd_frame(input logic [7:0] cmd, input logic [31:0] arg);
    add_byte(ssbf_pkg::FILL_BYTE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(cmd | ssbf_pkg::CMD_MARK, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(arg[31:24], 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(arg[23:16], 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(arg[15:8], 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(arg[7:0], 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(ssbf_pkg::CRC_BYTE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    add_byte(ssbf_pkg::FILL_BYTE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
  endtask

  // Filler clocks that end with the card deselected.
  task automatic add_release(input logic err);
    for (int i = 0; i < RELEASE_BYTES; i++)
      add_byte(ssbf_pkg::FILL_BYTE, (i != RELEASE_BYTES - 1), 1'b0, '0, '0, 1'b0, err);
  endtask

  task automatic close_stream();
    if (streaming) begin
      add_cmd_frame(ssbf_pkg::CMD_STOP, '0);
      add_release(1'b0);
    end
  endtask

  task automatic take_card_byte(input logic [7:0] b, input logic sel);
    logic [9:0] addr;
    logic       done;
    if (!streaming) begin
      add_byte(ssbf_pkg::FILL_BYTE, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    end else if (rx_phase == PH_DATA) begin
      if (bank_pos == '0) bank_id = sel;
      addr       = 10'(bank_id * BANK_SIZE + bank_pos);
      bank_pos   = bank_pos + 10'd1;
      sector_pos = sector_pos + 10'd1;
      done       = 1'b0;
      if (bank_pos >= BANK_SIZE) begin
        bank_pos = '0;
        done     = 1'b1;
      end
      if (sector_pos >= ssbf_pkg::SECTOR_BYTES) begin
        sector_pos = '0;
        crc_seen   = '0;
        rx_phase   = PH_CRC;
      end
      add_byte(ssbf_pkg::FILL_BYTE, 1'b1, 1'b1, addr, b, done, 1'b0);
    end else if (rx_phase == PH_CRC) begin
      crc_seen = crc_seen + 2'd1;
      if (crc_seen >= 2'd2) begin
        crc_seen   = '0;
        sector_num = sector_num + 32'd1;
        rx_phase   = PH_TOKEN;
        token_wait = '0;
      end
      add_byte(ssbf_pkg::FILL_BYTE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    end else if (b == ssbf_pkg::TOKEN) begin
      rx_phase   = PH_DATA;
      token_wait = '0;
      sector_pos = '0;
      add_byte(ssbf_pkg::FILL_BYTE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    end else begin
      token_wait = token_wait + 16'd1;
      // A count that wraps to zero also ends the wait.
      if (token_wait >= wait_limit || token_wait == '0) begin
        add_release(1'b1);
        streaming = 1'b0;
        clear_stream();
      end else begin
        add_byte(ssbf_pkg::FILL_BYTE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic predict_spi_bytes(input logic [1:0] mode, input logic [31:0] lba,
                                   input logic [7:0] b, input logic sel);
    item_bytes.delete();
    unique case (mode)
      ssbf_pkg::MODE_START: begin
        close_stream();
        sector_num = lba;
        clear_stream();
        add_cmd_frame(ssbf_pkg::CMD_READ_MB, {lba[22:0], 9'd0});
        streaming = 1'b1;
      end
      ssbf_pkg::MODE_STOP: begin
        close_stream();
        streaming = 1'b0;
        clear_stream();
      end
      ssbf_pkg::MODE_RX: take_card_byte(b, sel);
      default: ;
    endcase
    // Sector and activity reflect the state after the whole item.
    foreach (item_bytes[i]) begin
      item_bytes[i].sector = sector_num;
      item_bytes[i].active = streaming;
      item_bytes[i].last   = (i == item_bytes.size() - 1);
      spi_bytes_q.push_back(item_bytes[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  task automatic check_spi_byte();
    ssbf_pkg::res_t e;
    if (spi_bytes_q.size() == 0) begin
      $error("output transfer %0h with no result pending", m_axis_tdata);
      fails++;
    end else begin
      e = spi_bytes_q.pop_front();
      check_field("tx_byte", 32'(e.tx), 32'(m_axis_tdata[7:0]));
      check_field("chip_select", 32'(e.cs), 32'(m_axis_tdata[8]));
      check_field("buf_write", 32'(e.wr), 32'(m_axis_tdata[9]));
      check_field("buf_addr", 32'(e.addr), 32'(m_axis_tdata[19:10]));
      check_field("buf_data", 32'(e.data), 32'(m_axis_tdata[27:20]));
      check_field("bank_done", 32'(e.done), 32'(m_axis_tdata[28]));
      check_field("token_error", 32'(e.err), 32'(m_axis_tdata[29]));
      check_field("current_sector", e.sector, m_axis_tdata[61:30]);
      check_field("stream_active", 32'(e.active), 32'(m_axis_tdata[62]));
      check_field("last", 32'(e.last), 32'(m_axis_tlast));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streaming  = 1'b0;
      sector_num = '0;
      bank_id    = 1'b0;
      wait_limit = ssbf_pkg::TIMEOUT_RST;
      clear_stream();
      spi_bytes_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      // Compare before predicting, so a stray output never meets a fresh expectation.
      if (m_axis_tvalid && m_axis_tready) check_spi_byte();
      if (cfg_we_i) wait_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_spi_bytes(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32],
                          s_axis_tdata[40]);
      pending_o    <= spi_bytes_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for the SD card SPI stream bank filler.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned BANK_SIZE     = 262;
  localparam int unsigned RELEASE_BYTES = 10;
  // The tuser encoding that the block must ignore.
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  // Quiet cycles after the last result before the timeout register may change;
  // this covers items that produce no output but still pass through the block.
  localparam int unsigned DRAIN_CYCLES  = 40;
  // Length of the long receiver hold-off that backs the block up to its input.
  localparam int unsigned HOLD_CYCLES   = 300;
  // Random items per idling phase; the one full-sector session comes on top.
  localparam int unsigned PHASE_ITEMS   = 15;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata from bit 0: lba[31:0], rx_byte[39:32], bank_select[40], zero pad [47:41].
  logic [47:0] s_axis_tdata  = '0;
  // tuser from bit 0: mode[1:0].
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata from bit 0: tx_byte[7:0], chip_select[8], buf_write[9], buf_addr[19:10],
  // buf_data[27:20], bank_done[28], token_error[29], current_sector[61:30],
  // stream_active[62], zero pad [63].
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;

  // Idle rates in percent for each side, changed between phases.
  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 79;
  // The receiver hold-off is requested once by the stimulus and counted by the receiver.
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;
  // Shadow of the timeout register, used to shape the token waits.
  int unsigned cur_timeout = 65535;
  int unsigned items_sent  = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sd_spi_stream_bank_filler #(
    .BANK_SIZE    (BANK_SIZE),
    .RELEASE_BYTES(RELEASE_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  ssbf_checker #(
    .BANK_SIZE    (BANK_SIZE),
    .RELEASE_BYTES(RELEASE_BYTES)
  ) spi_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver: random back-pressure, except during the one long hold-off, which is
  // counted here so the sender keeps pushing items while the block backs up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offers one item after a random gap and returns at the edge of its transfer.
  // tvalid is left high, so back-to-back items keep it up without a glitch.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] lba,
                           input logic [7:0] rx, input logic sel);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, sel, rx, lba};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Drops tvalid, waits for every predicted result and lets the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_timeout = {16'd0, value};
  endtask

  // Start addresses lean toward the corners of the 32-bit range and the point where
  // the shift by nine drops bits.
  function automatic logic [31:0] pick_lba();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h0000_0000;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h007F_FFFF;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_card_byte(input logic [7:0] b);
    send_item(ssbf_pkg::MODE_RX, $urandom, b, 1'($urandom_range(0, 1)));
  endtask

  // A byte that the card sends while the host waits for the data token.
  task automatic send_wait_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ssbf_pkg::TOKEN);
    send_card_byte(b);
  endtask

  task automatic send_start();
    send_item(ssbf_pkg::MODE_START, pick_lba(), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_stop();
    send_item(ssbf_pkg::MODE_STOP, $urandom, 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  // One multi-block read: a start, a short token wait and the token, then either a full
  // sector with its two checksum bytes, the next token wait and a stop, or a few data
  // bytes cut off by a stop or a restart. With a short timeout some sessions run into
  // the token timeout instead.
  task automatic run_session(input logic full);
    int unsigned max_wait;
    int unsigned ndata;
    send_start();
    max_wait = (cur_timeout == 0) ? 0 : ((cur_timeout > 5) ? 4 : cur_timeout - 1);
    if (!full && cur_timeout <= 8 && $urandom_range(0, 99) < 25) begin
      // Never send the token, so the wait expires and the card is released.
      repeat ((cur_timeout == 0) ? 1 : cur_timeout) send_wait_byte();
      return;
    end
    repeat ($urandom_range(0, max_wait)) send_wait_byte();
    send_card_byte(ssbf_pkg::TOKEN);
    ndata = full ? ssbf_pkg::SECTOR_BYTES : $urandom_range(1, 12);
    repeat (ndata) send_card_byte(8'($urandom_range(0, 255)));
    if (full) begin
      repeat (2) send_card_byte(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, max_wait)) send_wait_byte();
      send_stop();
    end else if ($urandom_range(0, 1) != 0) begin
      send_stop();
    end else begin
      send_start();
    end
  endtask

  // Short sessions, with a tenth of the traffic being unrelated random items.
  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 10)
        send_item(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      else
        run_session(1'b0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with a short token timeout. Bytes and stops while idle, the unused
    // mode, a start at the top sector, a token wait, data into bank one, a stop of a
    // running stream, a restart and a token timeout.
    write_timeout(16'd3);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'h00, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'hFFFF_FFFF, ssbf_pkg::TOKEN, 1'b1);
    send_item(ssbf_pkg::MODE_STOP, 32'h0000_0000, 8'h00, 1'b0);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(ssbf_pkg::MODE_START, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'h00, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, ssbf_pkg::TOKEN, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'h00, 1'b0);
    send_item(MODE_UNUSED, 32'h0000_0000, 8'h00, 1'b0);
    send_item(ssbf_pkg::MODE_STOP, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    send_item(ssbf_pkg::MODE_START, 32'h0000_0000, 8'h00, 1'b0);
    send_item(ssbf_pkg::MODE_START, 32'h1234_5678, 8'hA5, 1'b1);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'h01, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'hFD, 1'b1);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'hFF, 1'b0);

    // A zero timeout lets the very first non-token byte expire the wait, while the
    // token itself is still taken.
    write_timeout(16'd0);
    send_item(ssbf_pkg::MODE_START, 32'h007F_FFFF, 8'h00, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'h55, 1'b1);
    send_item(ssbf_pkg::MODE_START, 32'hABCD_EF01, 8'h00, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, ssbf_pkg::TOKEN, 1'b0);
    send_item(ssbf_pkg::MODE_RX, 32'h0000_0000, 8'hAA, 1'b1);
    send_item(ssbf_pkg::MODE_STOP, 32'h0000_0000, 8'h00, 1'b0);

    // Random part, first with a slow receiver and a short timeout. One session reads
    // a whole sector, so a bank fills up and the sector number steps.
    write_timeout(16'd5);
    run_session(1'b1);
    run_phase(PHASE_ITEMS);

    // Slow sender, fast receiver, and the largest timeout.
    write_timeout(16'hFFFF);
    tx_idle_pct = 79;
    rx_idle_pct = 23;
    run_phase(PHASE_ITEMS);

    // No idling at all, the smallest legal timeout, and the long receiver hold-off at
    // the start so the queue fills while the sender keeps offering items.
    write_timeout(16'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_phase(PHASE_ITEMS);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("sd_spi_stream_bank_filler: match");
    end else begin
      $display("sd_spi_stream_bank_filler: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #6_400_000;
    $display("sd_spi_stream_bank_filler: mismatch");
    $finish;
  end

endmodule
